// ===== rtl/psg_pkg.sv =====
// Shared types, constants and the mod-251 reduction for the polynomial share generator.
package psg_pkg;

    // Field and modulus constants
    localparam int NUM_COEF_FIELDS = 8;
    localparam int COEF_W          = 8;
    localparam int THRESH_W        = 4;
    localparam int SHARE_CNT_W     = 5;
    localparam int SHARE_IDX_W     = 5;
    localparam int VALUE_W         = 8;
    localparam int CFG_DATA_W      = 5;
    localparam int CFG_IDX_W       = 1;
    // Horner step sum acc*x + c, wide enough for x up to 64
    localparam int SUM_W           = 14;
    localparam logic [8:0] PRIME   = 9'd251;

    localparam int DEF_MAX_COEFS  = 8;
    localparam int DEF_MAX_SHARES = 16;

    localparam logic [THRESH_W-1:0]    THRESH_RESET = 4'd2;
    localparam logic [SHARE_CNT_W-1:0] SHARES_RESET = 5'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_COUNT = 1'd1;

    typedef struct packed {
        logic [COEF_W-1:0] coef_0;
        logic [COEF_W-1:0] coef_1;
        logic [COEF_W-1:0] coef_2;
        logic [COEF_W-1:0] coef_3;
        logic [COEF_W-1:0] coef_4;
        logic [COEF_W-1:0] coef_5;
        logic [COEF_W-1:0] coef_6;
        logic [COEF_W-1:0] coef_7;
    } t_in_item;

    typedef struct packed {
        logic [SHARE_IDX_W-1:0] share_index;
        logic [VALUE_W-1:0]     share_value;
        logic                   last_share;
    } t_out_item;

    // Data carried by one token along the cell chain
    typedef struct packed {
        logic [NUM_COEF_FIELDS-1:0][COEF_W-1:0] coefs;
        logic [THRESH_W-1:0]                    k;
        logic                                   last;
        logic [VALUE_W-1:0]                     acc;
    } t_token;

    // Reduce a Horner sum modulo 251 using 256 = 5 (mod 251)
    function automatic logic [VALUE_W-1:0] mod251(input logic [SUM_W-1:0] v);
        logic [9:0] f1;
        logic [8:0] f2;
        f1 = 10'(v[SUM_W-1:8]) * 10'd5 + 10'(v[7:0]);
        f2 = 9'(f1[9:8]) * 9'd5 + 9'(f1[7:0]);
        if (f2 >= PRIME) begin
            f2 = f2 - PRIME;
        end
        return f2[VALUE_W-1:0];
    endfunction

endpackage

// ===== rtl/psg_seq.sv =====
// Sequencer: holds one pixel group and issues one token per evaluation point.
module psg_seq #(
    parameter int MAX_COEFS  = psg_pkg::DEF_MAX_COEFS,
    parameter int MAX_SHARES = psg_pkg::DEF_MAX_SHARES,
    parameter int XW         = $clog2(MAX_SHARES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  psg_pkg::t_in_item             i_item,
    input  logic [psg_pkg::THRESH_W-1:0]    i_threshold,
    input  logic [psg_pkg::SHARE_CNT_W-1:0] i_share_count,
    input  logic                          i_adv,
    output logic                          o_tok_valid,
    output logic [XW-1:0]                 o_tok_x,
    output psg_pkg::t_token               o_tok
);
    import psg_pkg::*;

    logic                                   r_busy;
    logic [NUM_COEF_FIELDS-1:0][COEF_W-1:0] r_coefs;
    logic [THRESH_W-1:0]                    r_k;
    logic [XW-1:0]                          r_n;
    logic [XW-1:0]                          r_x;
    logic [THRESH_W-1:0]                    n_k;
    logic [XW-1:0]                          n_n;
    logic                                   tok_last;
    logic                                   accept;

    // Clamp the configuration to its legal ranges
    always_comb begin
        if (i_threshold == '0) begin
            n_k = THRESH_W'(1);
        end else if (32'(i_threshold) > MAX_COEFS) begin
            n_k = THRESH_W'(MAX_COEFS);
        end else begin
            n_k = i_threshold;
        end
        if (i_share_count == '0) begin
            n_n = XW'(1);
        end else if (32'(i_share_count) > MAX_SHARES) begin
            n_n = XW'(MAX_SHARES);
        end else begin
            n_n = XW'(i_share_count);
        end
    end

    assign tok_last    = (r_x == r_n);
    assign o_ready     = !r_busy || (i_adv && tok_last);
    assign accept      = i_valid && o_ready;
    assign o_tok_valid = r_busy;
    assign o_tok_x     = r_x;

    always_comb begin
        o_tok.coefs = r_coefs;
        o_tok.k     = r_k;
        o_tok.last  = tok_last;
        o_tok.acc   = '0;
    end

    // Control: load a new item or step to the next evaluation point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (i_adv && tok_last) begin
            r_busy <= 1'b0;
        end
    end

    // Payload: capture the group and advance x
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coefs[0] <= i_item.coef_0;
            r_coefs[1] <= i_item.coef_1;
            r_coefs[2] <= i_item.coef_2;
            r_coefs[3] <= i_item.coef_3;
            r_coefs[4] <= i_item.coef_4;
            r_coefs[5] <= i_item.coef_5;
            r_coefs[6] <= i_item.coef_6;
            r_coefs[7] <= i_item.coef_7;
            r_k        <= n_k;
            r_n        <= n_n;
            r_x        <= XW'(1);
        end else if (i_adv && r_busy) begin
            r_x <= r_x + XW'(1);
        end
    end

endmodule

// ===== rtl/psg_cell.sv =====
// Horner cell: applies one coefficient, acc = (acc * x + c) mod 251.
module psg_cell #(
    parameter int IDX = 0,
    parameter int XW  = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  logic [XW-1:0]   i_x,
    input  psg_pkg::t_token i_tok,
    output logic            o_valid,
    output logic [XW-1:0]   o_x,
    output psg_pkg::t_token o_tok
);
    import psg_pkg::*;

    logic              r_valid;
    logic [XW-1:0]     r_x;
    t_token            r_tok;
    logic [COEF_W-1:0] coef;
    logic [SUM_W-1:0]  sum;
    t_token            n_tok;

    // Coefficient positions past the input fields count as zero
    generate
        if (IDX < NUM_COEF_FIELDS) begin : g_coef
            assign coef = i_tok.coefs[IDX];
        end else begin : g_zero
            assign coef = '0;
        end
    endgenerate

    // One Horner step; skip cells beyond the threshold
    always_comb begin
        sum   = SUM_W'(i_tok.acc) * SUM_W'(i_x) + SUM_W'(coef);
        n_tok = i_tok;
        if (32'(i_tok.k) > IDX) begin
            n_tok.acc = mod251(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x   <= i_x;
            r_tok <= n_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_tok   = r_tok;

endmodule

// ===== rtl/polynomial_share_generator_mod251.sv =====
// Top level: k-of-n polynomial share generator over GF(251) built as a Horner cell chain.
// Path: sequencer register, a Horner cell register per coefficient, output register.
// Throughput: one share per cycle unless the output stalls; an item gives n shares
// (n = clamped share_count), each from one evaluation point the sequencer feeds the chain.
// The whole chain stalls together while the output register holds an untaken share.
// Reset: chain and output empty, threshold = 2, share_count = 4.
module polynomial_share_generator_mod251 #(
    parameter int MAX_COEFS  = psg_pkg::DEF_MAX_COEFS,
    parameter int MAX_SHARES = psg_pkg::DEF_MAX_SHARES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [psg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  psg_pkg::t_in_item              i_item,
    output logic                           o_valid,
    input  logic                           i_ready,
    output psg_pkg::t_out_item             o_item
);
    import psg_pkg::*;

    localparam int XW = $clog2(MAX_SHARES + 1);

    logic [THRESH_W-1:0]    r_threshold;
    logic [SHARE_CNT_W-1:0] r_share_count;
    logic                   r_out_valid;
    t_out_item              r_out_item;
    logic                   adv;

    logic          chain_valid [0:MAX_COEFS];
    logic [XW-1:0] chain_x     [0:MAX_COEFS];
    t_token        chain_tok   [0:MAX_COEFS];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THRESH_RESET;
            r_share_count <= SHARES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data[THRESH_W-1:0];
                CFG_SHARE_COUNT: r_share_count <= i_cfg_data[SHARE_CNT_W-1:0];
                default:         r_threshold   <= r_threshold;
            endcase
        end
    end

    // Advance the whole chain whenever the output register can take a share
    assign adv = !r_out_valid || i_ready;

    psg_seq #(
        .MAX_COEFS  (MAX_COEFS),
        .MAX_SHARES (MAX_SHARES),
        .XW         (XW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_item        (i_item),
        .i_threshold   (r_threshold),
        .i_share_count (r_share_count),
        .i_adv         (adv),
        .o_tok_valid   (chain_valid[0]),
        .o_tok_x       (chain_x[0]),
        .o_tok         (chain_tok[0])
    );

    // Row of Horner cells, one per coefficient position
    generate
        for (genvar g = 0; g < MAX_COEFS; g++) begin : g_cell
            psg_cell #(
                .IDX (g),
                .XW  (XW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_valid (chain_valid[g]),
                .i_x     (chain_x[g]),
                .i_tok   (chain_tok[g]),
                .o_valid (chain_valid[g+1]),
                .o_x     (chain_x[g+1]),
                .o_tok   (chain_tok[g+1])
            );
        end
    endgenerate

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= chain_valid[MAX_COEFS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item.share_index <= SHARE_IDX_W'(chain_x[MAX_COEFS]);
            r_out_item.share_value <= chain_tok[MAX_COEFS].acc;
            r_out_item.last_share  <= chain_tok[MAX_COEFS].last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the mod-251 polynomial share generator.
`timescale 1ns / 1ps

module testbench;
    import psg_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_GROUPS  = 40;
    localparam int NUM_PHASES    = 10;

    // One pixel group waiting to be sent; hold makes the sender wait for a full drain first
    typedef struct {
        t_in_item group;
        bit       hold;
    } t_group_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;

    // Local copy of the configuration registers
    logic [THRESH_W-1:0]    thresh_reg = THRESH_RESET;
    logic [SHARE_CNT_W-1:0] shares_reg = SHARES_RESET;

    t_group_req pixel_groups[$];
    t_out_item  expected_shares[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    polynomial_share_generator_mod251 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (in_valid),
        .o_ready    (in_ready),
        .i_item     (in_item),
        .o_valid    (out_valid),
        .i_ready    (out_ready),
        .o_item     (out_item)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Evaluate the group polynomial at x by Horner's rule, reducing after each step
    function automatic logic [VALUE_W-1:0] horner_share(input t_in_item g, input int k,
                                                         input int x);
        logic [COEF_W-1:0] c[NUM_COEF_FIELDS];
        int acc;
        c = '{g.coef_0, g.coef_1, g.coef_2, g.coef_3, g.coef_4, g.coef_5, g.coef_6, g.coef_7};
        acc = 0;
        for (int i = 0; i < k; i++) begin
            acc = (acc * x + int'(c[i])) % int'(PRIME);
        end
        return VALUE_W'(acc);
    endfunction

    // Queue every share that one accepted group produces under the current settings
    task automatic queue_shares(input t_in_item g);
        int k;
        int n;
        t_out_item s;
        k = (thresh_reg == 0) ? 1 : (thresh_reg > DEF_MAX_COEFS) ? DEF_MAX_COEFS
                                                                  : int'(thresh_reg);
        n = (shares_reg == 0) ? 1 : (shares_reg > DEF_MAX_SHARES) ? DEF_MAX_SHARES
                                                                   : int'(shares_reg);
        for (int x = 1; x <= n; x++) begin
            s.share_index = SHARE_IDX_W'(x);
            s.share_value = horner_share(g, k, x);
            s.last_share  = (x == n);
            expected_shares.insert(expected_shares.size(), s);
        end
    endtask

    // Random group: mostly uniform bytes, some forced into the 251..255 band or to zero
    function automatic t_in_item rand_group();
        logic [NUM_COEF_FIELDS-1:0][COEF_W-1:0] b;
        int mode;
        mode = $urandom_range(15);
        for (int i = 0; i < NUM_COEF_FIELDS; i++) begin
            case ($urandom_range(7))
                0: begin
                    b[i] = COEF_W'($urandom_range(255, 251));
                end
                1: begin
                    b[i] = (mode == 0) ? '0 : COEF_W'($urandom);
                end
                default: begin
                    b[i] = COEF_W'($urandom);
                end
            endcase
        end
        return t_in_item'(b);
    endfunction

    // Write both registers back to back, then release the write enable
    task automatic set_config(input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] cnt);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_THRESHOLD;
        cfg_data <= thr;
        thresh_reg = thr[THRESH_W-1:0];
        @(posedge i_clk);
        cfg_idx  <= CFG_SHARE_COUNT;
        cfg_data <= cnt;
        shares_reg = cnt[SHARE_CNT_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Block until every group is sent and every share has come back, then settle
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pixel_groups.size() != 0 || in_valid || expected_shares.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: present the next pending group, advance on accept
    always @(posedge i_clk) begin : drive
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                queue_shares(in_item);
            end
            if (!in_valid || in_ready) begin
                if (pixel_groups.size() != 0 &&
                    !(pixel_groups[0].hold && expected_shares.size() != 0) &&
                    $urandom_range(99) >= idle_pct) begin
                    in_item  <= pixel_groups[0].group;
                    in_valid <= 1'b1;
                    void'(pixel_groups.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted share against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_shares.size() == 0) begin
                    report_mismatch($sformatf("unexpected share index %0d value %0d",
                                              out_item.share_index, out_item.share_value));
                end else begin
                    want = expected_shares.pop_front();
                    if (out_item.share_index !== want.share_index)
                        report_mismatch($sformatf("share_index got %0d want %0d",
                                                  out_item.share_index, want.share_index));
                    if (out_item.share_value !== want.share_value)
                        report_mismatch($sformatf("share_value x=%0d got %0d want %0d",
                                                  want.share_index, out_item.share_value,
                                                  want.share_value));
                    if (out_item.last_share !== want.last_share)
                        report_mismatch($sformatf("last_share x=%0d got %0b want %0b",
                                                  want.share_index, out_item.last_share,
                                                  want.last_share));
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item directed[12];
        logic [CFG_DATA_W-1:0] thr_set[NUM_PHASES];
        logic [CFG_DATA_W-1:0] cnt_set[NUM_PHASES];
        int idle_set[4];
        int stall_set[4];
        t_group_req req;

        directed = '{
            t_in_item'(64'h0000_0000_0000_0000), t_in_item'(64'hFFFF_FFFF_FFFF_FFFF),
            t_in_item'(64'hFBFB_FBFB_FBFB_FBFB), t_in_item'(64'hFAFA_FAFA_FAFA_FAFA),
            t_in_item'(64'hFCFD_FEFF_FBFC_FDFE), t_in_item'(64'hFF00_0000_0000_0000),
            t_in_item'(64'h00FF_0000_0000_0000), t_in_item'(64'h0000_0000_0000_00FF),
            t_in_item'(64'hAAAA_AAAA_AAAA_AAAA), t_in_item'(64'h5555_5555_5555_5555),
            t_in_item'(64'h0102_0304_0506_0708), t_in_item'(64'h8040_2010_0804_0201)
        };
        // Threshold and count settings: zero, minimum, maximum, over-range and masked
        thr_set = '{5'd0, 5'd1, 5'd8, 5'd31, 5'd24, 5'd9, 5'd3, 5'd5, 5'd7, 5'd18};
        cnt_set = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd5, 5'd12, 5'd16, 5'd7, 5'd2};
        // Idle modes: none, sender idle, receiver stall, both
        idle_set  = '{0, 85, 0, 20};
        stall_set = '{0, 0, 85, 20};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed groups under the reset settings, then with all coefficients and shares
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                set_config(5'd8, 5'd16);
            end
            for (int i = 0; i < 12; i++) begin
                req.group = directed[i];
                req.hold  = 1'b0;
                pixel_groups.insert(pixel_groups.size(), req);
            end
            wait_drained();
        end

        // Random phases, each under its own settings and idle mode
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(thr_set[p], cnt_set[p]);
            idle_pct  = idle_set[p % 4];
            stall_pct = stall_set[p % 4];
            for (int i = 0; i < PHASE_GROUPS; i++) begin
                req.group = rand_group();
                req.hold  = (p % 4 == 0) && (i % 8 == 7);
                pixel_groups.insert(pixel_groups.size(), req);
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
